>>> src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Transaction structs, operation and status codes, default capacity.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int WORD_W           = 32;
  localparam int COUNT_W          = 11;
  localparam int OP_W             = 3;
  localparam int STATUS_W         = 2;
  localparam int DEFAULT_CAPACITY = 1024;

  localparam logic [WORD_W-1:0] MINUS_ONE = '1;

  localparam logic [OP_W-1:0] OP_REPORT     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       element_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/deq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/deq_ctrl.sv
// Queue controller: head/tail/count, cached end words, RAM access sequencing.
// Depends on deq_pkg; drives the word RAM ports of the top level.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire deq_pkg::in_item_t           in_data,
  output logic                             in_stall,
  input  wire logic                        res_free,
  output logic                             res_valid,
  output deq_pkg::out_item_t               res_data,
  output logic                             ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
  output logic [deq_pkg::WORD_W-1:0]       ram_wr_data,
  output logic                             ram_rd_en,
  output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
  input  wire logic [deq_pkg::WORD_W-1:0]  ram_rd_data
);

  import deq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic              state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              side_front_r, side_front_nxt;

  logic              accept;
  logic [WORD_W-1:0] popped;
  logic [STATUS_W-1:0] status;
  logic              fetch;
  logic              now_empty;
  out_item_t         res_new;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
  endfunction

  assign in_stall = (state_r != S_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    pend_nxt       = pend_r;
    side_front_nxt = side_front_r;
    popped         = '0;
    status         = ST_OK;
    fetch          = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = head_r;
    ram_wr_data    = in_data.push_value;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = head_r;
    res_valid      = 1'b0;

    if (state_r == S_IDLE) begin
      if (accept) begin
        case (in_data.opcode)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (count_r == CAP_CNT) begin
              status = ST_FULL;
            end else begin
              ram_wr_en = 1'b1;
              count_nxt = count_r + ONE_CNT;
              if (in_data.opcode == OP_PUSH_FRONT) begin
                head_nxt    = idx_dec(head_r);
                ram_wr_addr = head_nxt;
                front_nxt   = in_data.push_value;
                if (count_r == '0) begin
                  back_nxt = in_data.push_value;
                end
              end else begin
                tail_nxt    = idx_inc(tail_r);
                ram_wr_addr = tail_nxt;
                back_nxt    = in_data.push_value;
                if (count_r == '0) begin
                  front_nxt = in_data.push_value;
                end
              end
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (count_r == '0) begin
              status = ST_EMPTY;
              popped = MINUS_ONE;
            end else begin
              count_nxt = count_r - ONE_CNT;
              // new end word must come from the RAM unless the queue drains
              fetch     = (count_r != ONE_CNT);
              ram_rd_en = fetch;
              side_front_nxt = (in_data.opcode == OP_POP_FRONT);
              if (in_data.opcode == OP_POP_FRONT) begin
                popped      = front_r;
                head_nxt    = idx_inc(head_r);
                ram_rd_addr = head_nxt;
              end else begin
                popped      = back_r;
                tail_nxt    = idx_dec(tail_r);
                ram_rd_addr = tail_nxt;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    now_empty              = (count_nxt == '0);
    res_new.popped_value   = popped;
    res_new.status         = status;
    res_new.element_count  = COUNT_W'(count_nxt);
    res_new.is_empty       = now_empty;
    res_new.front_value    = now_empty ? MINUS_ONE : front_nxt;
    res_new.back_value     = now_empty ? MINUS_ONE : back_nxt;
    res_data               = res_new;

    if (state_r == S_IDLE) begin
      if (accept) begin
        if (fetch) begin
          pend_nxt  = res_new;
          state_nxt = S_FETCH;
        end else begin
          res_valid = 1'b1;
        end
      end
    end else begin
      res_data = pend_r;
      if (side_front_r) begin
        res_data.front_value = ram_rd_data;
      end else begin
        res_data.back_value = ram_rd_data;
      end
      if (res_free) begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (side_front_r) begin
          front_nxt = ram_rd_data;
        end else begin
          back_nxt = ram_rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= LAST_IDX;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    pend_r       <= pend_nxt;
    side_front_r <= side_front_nxt;
  end

endmodule

`default_nettype wire

>>> src/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words.
// Input channel (in_valid/in_stall/in_data) carries one operation per transaction:
// report, push front, push back, pop front or pop back. Every operation yields
// exactly one result transaction on out_valid/out_stall/out_data with the popped
// word, a status code, the element count, an empty flag and the front/back words.
// Words live in a CAPACITY-deep RAM with registered read; the front and back
// words are also cached in registers.
// Report and push operations leave their result in the output register the
// cycle after the transaction. A pop that leaves words behind first reads the
// RAM to refresh the cached end word: the controller enters its fetch state,
// and the result loads into the output register once the output is free.
// A new transaction is taken whenever the controller is idle and the output
// register is empty or being drained in the same cycle.
// Reset empties the queue (head, count cleared; tail to last index) and drops
// any pending result; RAM contents are not cleared and need no clearing pass.
// While out_stall is high with a result pending, the result holds and in_stall rises.
// Depends on deq_pkg, deq_ctrl and deq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire deq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output deq_pkg::out_item_t      out_data
);

  import deq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              res_free;
  logic              res_valid;
  out_item_t         res_data;
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  assign res_free = !out_valid_r || !out_stall;

  deq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .res_free    (res_free),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register: loads a new result, or empties once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> src/deq_checker.sv
// Port-level checks for double_ended_queue_core, attached by bind.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire deq_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire deq_pkg::out_item_t out_data
);

  import deq_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && !in_stall && (in_data.opcode == OP_REPORT);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.element_count == '0 && out_data.front_value == MINUS_ONE &&
      out_data.back_value == MINUS_ONE)
    else $error("empty queue reports stale end words or count");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.popped_value == MINUS_ONE && out_data.is_empty)
    else $error("pop on empty inconsistent");

  // a report transaction, taken while the output is free, shows its result in the next cycle
  a_report_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_seen |=> out_valid && out_data.status == ST_OK &&
      out_data.popped_value == '0)
    else $error("report result missing or wrong");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

`default_nettype wire
